// File: sv/colt_pkg.sv
package colt_pkg;

	// default sizing of the list
	localparam int MAX_ENTRIES_DEF = 16;
	localparam int ITEM_BITS_DEF   = 32;

	// operation codes
	localparam logic [2:0] OP_APPEND    = 3'd0;
	localparam logic [2:0] OP_GET       = 3'd1;
	localparam logic [2:0] OP_REMOVE_AT = 3'd2;
	localparam logic [2:0] OP_REMOVE_BY = 3'd3;
	localparam logic [2:0] OP_INDEX_OF  = 3'd4;
	localparam logic [2:0] OP_CLEAR     = 3'd5;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_RANGE     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] item_value;
		logic [3:0]  position;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  found_position;
		logic [31:0] read_value;
		logic [4:0]  entry_count;
	} res_t;

endpackage

// File: sv/colt_ram.sv
module colt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/compacting_ordered_list_table_top.sv
// Ordered, densely packed list of up to MAX_ENTRIES entries of ITEM_BITS bits with a live count.
// One request is taken at a time; req_ready is high only while the sequencer is idle, and a
// finished response waits in its own register so the next request can be taken meanwhile.
// Append, clear, the spare codes and the full, empty and out-of-range cases go straight from
// the accepting idle state to the finish state; get passes through a fetch state; index-of and
// remove-by-value search the live entries in order; remove-at and a remove-by-value hit walk
// the later entries down. The single entry memory gives one read per cycle to the search and
// the shift-down walks. While an earlier response is still stalled, the finish state waits until
// it is taken. Entry contents are undefined after reset and are never read before written, so
// no clearing pass is needed.
module compacting_ordered_list_table_top
	import colt_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int ITEM_BITS   = ITEM_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int PW = (CW > 4) ? CW : 4;
	localparam int VW = (ITEM_BITS < 32) ? ITEM_BITS : 32;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_FETCH  = 5'b00010,
		S_SEARCH = 5'b00100,
		S_SHIFT  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [2:0]           op_q;
	logic [ITEM_BITS-1:0] val_q;
	logic [CW-1:0]        idx_q;
	logic [AW-1:0]        idx_s1;
	logic                 vld_s1;
	logic [2:0]           status_q;
	logic [AW-1:0]        where_q;
	logic [31:0]          rd_q;
	logic                 res_valid_q;
	res_t                 res_q;

	logic                 accept;
	logic                 is_empty;
	logic                 is_full;
	logic                 pos_range;
	logic [ITEM_BITS-1:0] req_val;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ITEM_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [ITEM_BITS-1:0] ram_rdata;
	logic                 hit;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CW'(MAX_ENTRIES));
	assign pos_range = (PW'(req.position) >= PW'(count_q));
	assign req_val   = ITEM_BITS'(req.item_value[VW-1:0]);
	assign hit       = vld_s1 && (ram_rdata == val_q);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// memory port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = req_val;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_we    = accept && (req.operation == OP_APPEND) && !is_full;
				ram_re    = accept && (req.operation == OP_GET) && !is_empty && !pos_range;
				ram_raddr = AW'(req.position);
			end
			S_SEARCH: begin
				ram_re = !hit && (idx_q < count_q);
			end
			S_SHIFT: begin
				ram_we    = vld_s1;
				ram_waddr = idx_s1 - AW'(1);
				ram_wdata = ram_rdata;
				ram_re    = (idx_q < count_q);
			end
			S_FETCH, S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			op_q        <= OP_APPEND;
			val_q       <= '0;
			idx_q       <= '0;
			idx_s1      <= '0;
			vld_s1      <= 1'b0;
			status_q    <= ST_OK;
			where_q     <= '0;
			rd_q        <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// response taken and no new one loaded this cycle
			if (res_valid_q && res_ready && (state_q != S_FINISH)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= req.operation;
						val_q    <= req_val;
						status_q <= ST_OK;
						where_q  <= '0;
						rd_q     <= '0;
						vld_s1   <= 1'b0;
						state_q  <= S_FINISH;
						unique case (req.operation)
							OP_APPEND: begin
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_GET, OP_REMOVE_AT: begin
								if (is_empty) begin
									status_q <= ST_EMPTY;
								end else if (pos_range) begin
									status_q <= ST_RANGE;
								end else if (req.operation == OP_GET) begin
									state_q <= S_FETCH;
								end else begin
									idx_q   <= CW'(req.position) + CW'(1);
									state_q <= S_SHIFT;
								end
							end
							OP_REMOVE_BY, OP_INDEX_OF: begin
								idx_q   <= '0;
								state_q <= S_SEARCH;
							end
							OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_FETCH: begin
					rd_q    <= 32'(ram_rdata[VW-1:0]);
					state_q <= S_FINISH;
				end
				// walk entries, compare each read result in the cycle after its read
				S_SEARCH: begin
					if (hit) begin
						where_q <= idx_s1;
						vld_s1  <= 1'b0;
						if (op_q == OP_REMOVE_BY) begin
							idx_q   <= CW'(idx_s1) + CW'(1);
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_FINISH;
						end
					end else if (idx_q < count_q) begin
						idx_s1 <= idx_q[AW-1:0];
						vld_s1 <= 1'b1;
						idx_q  <= idx_q + CW'(1);
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_FINISH;
						end
					end
				end
				// move later entries down one slot, write each entry in the cycle after its read
				S_SHIFT: begin
					if (idx_q < count_q) begin
						idx_s1 <= idx_q[AW-1:0];
						vld_s1 <= 1'b1;
						idx_q  <= idx_q + CW'(1);
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							count_q <= count_q - CW'(1);
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (!res_valid_q || res_ready) begin
						res_q.status         <= status_q;
						res_q.found_position <= 4'(where_q);
						res_q.read_value     <= rd_q;
						res_q.entry_count    <= 5'(count_q);
						res_valid_q          <= 1'b1;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	colt_ram #(
		.WIDTH(ITEM_BITS),
		.DEPTH(MAX_ENTRIES)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

// File: sv/colt_checker.sv
module colt_checker
	import colt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// a stalled response stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("response dropped while stalled");

	// a stalled response keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("response payload changed while stalled");

	// the block is busy in the cycle after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	// failed requests return no data and no position
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != ST_OK) |-> (res.read_value == '0) && (res.found_position == '0))
		else $error("failed request returned data");

endmodule

bind compacting_ordered_list_table_top colt_checker u_colt_checker (.*);

// File: bench/tb_compacting_ordered_list_table_top.sv
module tb_compacting_ordered_list_table_top;
	import colt_pkg::*;

	localparam int          CLK_PERIOD  = 20;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          SETTLE_CYCLES = 60;
	localparam int          RANDOM_ITEMS = 800;
	localparam int          POOL_SIZE   = 8;
	// operation codes the block must ignore
	localparam logic [2:0]  OP_SPARE_LO = 3'd6;
	localparam logic [2:0]  OP_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	// list contents as the block should hold them
	logic [31:0] shadow_entries [MAX_ENTRIES_DEF];
	int          shadow_count = 0;

	res_t        pending_results [$];
	logic [31:0] value_pool [POOL_SIZE];
	int          mismatch_count = 0;
	int          results_checked = 0;
	int          requests_sent = 0;
	int          status_seen [5] = '{default: 0};
	int          cycle_count = 0;
	int          ready_hold = 0;
	bit          sender_burst = 1'b0;
	bit          receiver_burst = 1'b0;
	bit          filling = 1'b1;

	compacting_ordered_list_table_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// clock
	initial begin
		forever begin
			#(CLK_PERIOD / 2) clk = ~clk;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d responses outstanding", $time,
				cycle_count, pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// close the gap left by a removed entry
	function automatic void shift_down_from(input int idx);
		for (int k = idx; k + 1 < shadow_count; k++) begin
			shadow_entries[k] = shadow_entries[k + 1];
		end
		shadow_count--;
	endfunction

	// apply one request to the shadow list and return the response it should give
	function automatic res_t apply_list_op(input req_t r);
		res_t o;
		int   hit;
		o = '0;
		hit = -1;
		case (r.operation)
			OP_APPEND: begin
				if (shadow_count >= MAX_ENTRIES_DEF) begin
					o.status = ST_FULL;
				end else begin
					shadow_entries[shadow_count] = r.item_value;
					shadow_count++;
				end
			end
			OP_GET, OP_REMOVE_AT: begin
				if (shadow_count == 0) begin
					o.status = ST_EMPTY;
				end else if (int'(r.position) >= shadow_count) begin
					o.status = ST_RANGE;
				end else if (r.operation == OP_GET) begin
					o.read_value = shadow_entries[r.position];
				end else begin
					shift_down_from(int'(r.position));
				end
			end
			OP_REMOVE_BY, OP_INDEX_OF: begin
				for (int k = 0; k < shadow_count && hit < 0; k++) begin
					if (shadow_entries[k] == r.item_value) begin
						hit = k;
					end
				end
				if (hit < 0) begin
					o.status = ST_NOT_FOUND;
				end else begin
					o.found_position = hit[3:0];
					if (r.operation == OP_REMOVE_BY) begin
						shift_down_from(hit);
					end
				end
			end
			OP_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		o.entry_count = shadow_count[4:0];
		return o;
	endfunction

	// drive one request and record its expected response once taken
	task automatic send_request(input logic [2:0] op, input logic [31:0] value,
			input logic [3:0] pos);
		req_t r;
		int   gap;
		r.operation = op;
		r.item_value = value;
		r.position = pos;
		gap = sender_burst ? 0 : $urandom_range(0, 8);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		do begin
			@(posedge clk);
		end while (!req_ready);
		pending_results.push_back(apply_list_op(r));
		requests_sent++;
	endtask

	// response ready with random stalls
	initial begin
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				res_ready <= 1'b0;
				ready_hold--;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// compare each response with the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			ready_hold = receiver_burst ? 0 : $urandom_range(0, 8);
			if (res.status < 3'd5) begin
				status_seen[res.status]++;
			end
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response %h", $time, res);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (res.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, res.status);
					mismatch_count++;
				end
				if (res.found_position !== want.found_position) begin
					$display("%0t: found_position expected %0d actual %0d", $time,
						want.found_position, res.found_position);
					mismatch_count++;
				end
				if (res.read_value !== want.read_value) begin
					$display("%0t: read_value expected %h actual %h", $time,
						want.read_value, res.read_value);
					mismatch_count++;
				end
				if (res.entry_count !== want.entry_count) begin
					$display("%0t: entry_count expected %0d actual %0d", $time,
						want.entry_count, res.entry_count);
					mismatch_count++;
				end
			end
		end
	end

	// get, remove-at and index-of on an empty list
	task automatic test_empty_list();
		send_request(OP_GET, 32'h0, 4'd0);
		send_request(OP_REMOVE_AT, 32'h0, 4'd15);
		send_request(OP_INDEX_OF, 32'h0, 4'd0);
	endtask

	// fill to capacity with extreme and repeated values, then one append too many
	task automatic test_fill_to_capacity();
		logic [31:0] v;
		for (int k = 0; k < MAX_ENTRIES_DEF; k++) begin
			case (k)
				0: v = 32'h0000_0000;
				1: v = 32'hFFFF_FFFF;
				2: v = 32'h8000_0001;
				3, 9: v = 32'h1234_5678;
				default: v = $urandom;
			endcase
			send_request(OP_APPEND, v, 4'($urandom_range(0, 15)));
		end
		send_request(OP_APPEND, 32'hDEAD_BEEF, 4'd0);
	endtask

	// searches with duplicates, removal at both ends, range errors, spare codes and a clear
	task automatic test_edge_cases();
		send_request(OP_GET, 32'h0, 4'd15);
		send_request(OP_INDEX_OF, 32'h1234_5678, 4'd0);
		send_request(OP_REMOVE_BY, 32'h1234_5678, 4'd0);
		send_request(OP_INDEX_OF, 32'h1234_5678, 4'd0);
		send_request(OP_REMOVE_AT, 32'h0, 4'd0);
		send_request(OP_GET, 32'h0, 4'd15);
		send_request(OP_REMOVE_AT, 32'h0, 4'd13);
		send_request(OP_REMOVE_BY, 32'hCAFE_F00D, 4'd0);
		send_request(OP_SPARE_LO, 32'hFFFF_FFFF, 4'd15);
		send_request(OP_SPARE_HI, 32'h0, 4'd0);
		send_request(OP_CLEAR, 32'h0, 4'd0);
		send_request(OP_REMOVE_BY, 32'h0, 4'd0);
	endtask

	// random mix that swings the list between empty and full
	task automatic test_random_mix(input int n);
		int          roll;
		logic [2:0]  op;
		logic [31:0] value;
		logic [3:0]  pos;
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0) begin
				sender_burst = ($urandom_range(0, 3) == 0);
				receiver_burst = ($urandom_range(0, 3) == 0);
			end
			if (shadow_count >= MAX_ENTRIES_DEF) begin
				filling = 1'b0;
			end else if (shadow_count == 0) begin
				filling = 1'b1;
			end else if ($urandom_range(0, 99) == 0) begin
				filling = !filling;
			end
			if ($urandom_range(0, 15) == 0) begin
				value_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
			end

			roll = $urandom_range(0, 99);
			if (roll < 2) begin
				op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
			end else if (roll < 4) begin
				op = OP_CLEAR;
			end else if (filling) begin
				op = roll < 50 ? OP_APPEND : roll < 62 ? OP_GET : roll < 72 ? OP_REMOVE_AT :
					roll < 84 ? OP_REMOVE_BY : OP_INDEX_OF;
			end else begin
				op = roll < 24 ? OP_APPEND : roll < 40 ? OP_GET : roll < 60 ? OP_REMOVE_AT :
					roll < 80 ? OP_REMOVE_BY : OP_INDEX_OF;
			end

			// values mostly from a small pool so searches hit, sometimes a live entry
			roll = $urandom_range(0, 99);
			if ((op == OP_REMOVE_BY || op == OP_INDEX_OF) && shadow_count > 0 && roll < 50) begin
				value = shadow_entries[$urandom_range(0, shadow_count - 1)];
			end else if (roll < 80) begin
				value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
			end else begin
				value = $urandom;
			end

			// positions mostly within or just past the live entries
			if ($urandom_range(0, 9) < 7) begin
				pos = 4'($urandom_range(0, shadow_count > 15 ? 15 : shadow_count));
			end else begin
				pos = 4'($urandom_range(0, 15));
			end
			send_request(op, value, pos);
		end
		sender_burst = 1'b0;
		receiver_burst = 1'b0;
	endtask

	// sender holds off until every response is back
	task automatic test_pause_until_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		send_request(OP_GET, 32'h0, 4'd0);
	endtask

	initial begin
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		for (int k = 2; k < POOL_SIZE; k++) begin
			value_pool[k] = $urandom;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_fill_to_capacity();
		test_edge_cases();
		test_random_mix(RANDOM_ITEMS);
		test_pause_until_drained();
		test_random_mix(RANDOM_ITEMS);

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests of all eight operation codes, %0d responses compared",
			requests_sent, results_checked);
		$display("responses by status: ok %0d, empty %0d, range %0d, not found %0d, full %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
